// ===== hdl/swg_pkg.sv =====
// Shared widths, sideband type and series coefficients for the SwiGLU pipeline.
`timescale 1ns / 1ps
`default_nettype none
package swg_pkg;

  localparam int MAG_W         = 16;  // magnitude of a Q3.12 input
  localparam int ACC_W         = 37;  // series accumulator, Q.24, holds e^8 and 1 + e^8
  localparam int FRAC_W        = 24;  // fractional bits of the series
  localparam int A_SH          = 12;  // |g| in Q.12 to a in Q.24
  localparam int Q_W           = 25;  // reciprocal quotient, at most 1.0 in Q.24
  localparam int NUM_W         = 2 * FRAC_W + 1;
  localparam int TERMS_W       = 4;
  localparam int MAX_TERMS     = 10;
  localparam int HORNER_STAGES = MAX_TERMS;
  localparam int DIV_STAGES    = Q_W;
  localparam int PROD_STAGES   = 3;
  localparam int OUT_W         = 32;
  localparam int PIPE_LATENCY  = 1 + HORNER_STAGES + 1 + DIV_STAGES + PROD_STAGES;

  typedef struct packed {
    logic             gate_neg;
    logic             prod_neg;
    logic [MAG_W-1:0] gate_mag;
    logic [MAG_W-1:0] up_mag;
    logic             last;
  } side_t;

  // 1/i! in unsigned Q.24, rounded to nearest
  function automatic logic [ACC_W-1:0] exp_coef(input logic [TERMS_W-1:0] idx);
    logic [ACC_W-1:0] c;
    case (idx)
      4'd0:    c = ACC_W'(16777216);
      4'd1:    c = ACC_W'(16777216);
      4'd2:    c = ACC_W'(8388608);
      4'd3:    c = ACC_W'(2796203);
      4'd4:    c = ACC_W'(699051);
      4'd5:    c = ACC_W'(139810);
      4'd6:    c = ACC_W'(23302);
      4'd7:    c = ACC_W'(3329);
      4'd8:    c = ACC_W'(416);
      4'd9:    c = ACC_W'(46);
      default: c = ACC_W'(5);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/swg_horner.sv =====
// Pipelined Horner evaluation of the truncated exp series on |gate|.
`timescale 1ns / 1ps
`default_nettype none
module swg_horner (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  input  swg_pkg::side_t              in_side,
  input  wire [swg_pkg::TERMS_W-1:0]  terms,
  output logic                        out_valid,
  output swg_pkg::side_t              out_side,
  output logic [swg_pkg::ACC_W-1:0]   out_exp
);
  import swg_pkg::*;

  logic [TERMS_W-1:0] n_eff;
  logic [ACC_W-1:0]   acc  [HORNER_STAGES+1];
  logic               vld  [HORNER_STAGES+1];
  side_t              sd   [HORNER_STAGES+1];

  assign n_eff = (terms > TERMS_W'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS) : terms;

  // seed with the highest coefficient in use
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    acc[0] <= exp_coef(n_eff);
    sd[0]  <= in_side;
  end

  for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_step
    localparam int I = HORNER_STAGES - 1 - k;
    localparam int PW = ACC_W + MAG_W;
    logic [PW-1:0]    prod;
    logic [PW-1:0]    rnd;
    logic [ACC_W-1:0] acc_next;

    always_comb begin
      prod = PW'(acc[k]) * PW'(sd[k].gate_mag);
      rnd  = prod + PW'(1 << (A_SH - 1));
      // step only the terms in use, pass the seed through the rest
      if (n_eff > TERMS_W'(I)) begin
        acc_next = exp_coef(TERMS_W'(I)) + rnd[ACC_W+FRAC_W-A_SH-1:FRAC_W-A_SH];
      end else begin
        acc_next = acc[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      acc[k+1] <= acc_next;
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[HORNER_STAGES];
  assign out_side  = sd[HORNER_STAGES];
  assign out_exp   = acc[HORNER_STAGES];

endmodule
`default_nettype wire

// ===== hdl/swg_recip.sv =====
// Pipelined restoring divider: rounded 1/(1+E) in Q.24, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module swg_recip (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  swg_pkg::side_t             in_side,
  input  wire [swg_pkg::ACC_W-1:0]   in_exp,
  output logic                       out_valid,
  output swg_pkg::side_t             out_side,
  output logic [swg_pkg::Q_W-1:0]    out_recip
);
  import swg_pkg::*;

  logic [ACC_W-1:0] den_in;
  logic [NUM_W-1:0] num_in;
  logic [ACC_W-1:0] den  [DIV_STAGES+1];
  logic [ACC_W-1:0] rem  [DIV_STAGES+1];
  logic [Q_W-1:0]   quo  [DIV_STAGES+1];
  logic [Q_W-1:0]   nlow [DIV_STAGES+1];
  logic             vld  [DIV_STAGES+1];
  side_t            sd   [DIV_STAGES+1];

  assign den_in = ACC_W'(1 << FRAC_W) + in_exp;
  assign num_in = (NUM_W'(1) << (2 * FRAC_W)) + NUM_W'(den_in >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    den[0]  <= den_in;
    rem[0]  <= ACC_W'(num_in[NUM_W-1:Q_W]);
    nlow[0] <= num_in[Q_W-1:0];
    quo[0]  <= '0;
    sd[0]   <= in_side;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_bit
    logic [ACC_W:0]   trial;
    logic [ACC_W-1:0] rem_next;
    logic             qbit;

    always_comb begin
      trial = {rem[j], nlow[j][DIV_STAGES-1-j]};
      qbit  = (trial >= {1'b0, den[j]});
      rem_next = qbit ? ACC_W'(trial - {1'b0, den[j]}) : ACC_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      den[j+1]  <= den[j];
      rem[j+1]  <= rem_next;
      nlow[j+1] <= nlow[j];
      quo[j+1]  <= {quo[j][Q_W-2:0], qbit};
      sd[j+1]   <= sd[j];
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_side  = sd[DIV_STAGES];
  assign out_recip = quo[DIV_STAGES];

endmodule
`default_nettype wire

// ===== hdl/swg_product.sv =====
// Sigmoid mirror, gate * sigmoid * up product and rounding to Q7.24.
`timescale 1ns / 1ps
`default_nettype none
module swg_product (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  swg_pkg::side_t             in_side,
  input  wire [swg_pkg::Q_W-1:0]     in_recip,
  output logic                       out_valid,
  output logic [swg_pkg::OUT_W-1:0]  out_result,
  output logic                       out_last
);
  import swg_pkg::*;

  localparam int P1_W = MAG_W + Q_W;
  localparam int P2_W = P1_W + MAG_W;

  logic [Q_W-1:0]   sig;
  logic [P1_W-1:0]  p1;
  logic [P2_W-1:0]  p2;
  logic [P2_W-1:0]  p2_rnd;
  logic [OUT_W-1:0] rmag;
  logic             v1;
  logic             v2;
  side_t            sd1;
  side_t            sd2;

  assign sig = in_side.gate_neg ? in_recip : (Q_W'(1 << FRAC_W) - in_recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    p1         <= P1_W'(in_side.gate_mag) * P1_W'(sig);
    sd1        <= in_side;
    p2         <= P2_W'(p1) * P2_W'(sd1.up_mag);
    sd2        <= sd1;
    out_result <= sd2.prod_neg ? (~rmag + OUT_W'(1)) : rmag;
    out_last   <= sd2.last;
  end

  // round half away from zero on the magnitude
  assign p2_rnd = p2 + P2_W'(1 << (FRAC_W - 1));
  assign rmag   = p2_rnd[OUT_W+FRAC_W-1:FRAC_W];

endmodule
`default_nettype wire

// ===== hdl/swiglu_activation.sv =====
// Top level of the SwiGLU activation pipeline.
`timescale 1ns / 1ps
`default_nettype none
// SwiGLU activation: each item (gate, up in signed Q3.12) yields one result,
// gate * sigmoid(gate) * up in signed Q7.24, with last_element copied to last_out.
// The block takes one item every clock cycle; busy is never raised. Each result
// appears on result_valid for one cycle only, in input order; the receiver cannot
// hold it off and must take it then. Each item passes through three pipelines:
// ten Horner stages for exp(|gate|) (one 37x16 multiply each), 25 stages of a
// restoring divider for 1/(1+e^|gate|) (one quotient bit each), and three stages for
// the mirror, the two multiplies and the rounding, plus the two entry registers.
// series_terms (reset 10, values above 10 act as 10, 0 gives sigmoid 0.5) is
// written through cfg_we/cfg_data and must only change while no item is in flight.
module swiglu_activation (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [15:0]           gate_value,
  input  wire signed [15:0]           up_value,
  input  wire                         last_element,
  input  wire                         cfg_we,
  input  wire [swg_pkg::TERMS_W-1:0]  cfg_data,
  output logic                        result_valid,
  output logic signed [31:0]          gated_product,
  output logic                        last_out
);
  import swg_pkg::*;

  logic [TERMS_W-1:0] series_terms;
  logic [MAG_W-1:0]   graw;
  logic [MAG_W-1:0]   uraw;
  side_t              in_side;
  logic               h_valid;
  side_t              h_side;
  logic [ACC_W-1:0]   h_exp;
  logic               r_valid;
  side_t              r_side;
  logic [Q_W-1:0]     r_recip;
  logic [OUT_W-1:0]   result;

  // hold the series length
  always_ff @(posedge clk) begin
    if (rst) begin
      series_terms <= TERMS_W'(MAX_TERMS);
    end else if (cfg_we) begin
      series_terms <= cfg_data;
    end
  end

  // fully pipelined: never stall the sender
  assign busy = 1'b0;

  // split signs from magnitudes once, carry them down the pipe
  assign graw = gate_value;
  assign uraw = up_value;
  always_comb begin
    in_side.gate_neg = graw[MAG_W-1];
    in_side.prod_neg = graw[MAG_W-1] ^ uraw[MAG_W-1];
    in_side.gate_mag = graw[MAG_W-1] ? (~graw + MAG_W'(1)) : graw;
    in_side.up_mag   = uraw[MAG_W-1] ? (~uraw + MAG_W'(1)) : uraw;
    in_side.last     = last_element;
  end

  swg_horner u_horner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_side   (in_side),
    .terms     (series_terms),
    .out_valid (h_valid),
    .out_side  (h_side),
    .out_exp   (h_exp)
  );

  swg_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .in_side   (h_side),
    .in_exp    (h_exp),
    .out_valid (r_valid),
    .out_side  (r_side),
    .out_recip (r_recip)
  );

  swg_product u_product (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (r_valid),
    .in_side    (r_side),
    .in_recip   (r_recip),
    .out_valid  (result_valid),
    .out_result (result),
    .out_last   (last_out)
  );

  assign gated_product = result;

`ifndef SYNTHESIS
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, PIPE_LATENCY))
    else $error("result without a matching item");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_out == $past(last_element, PIPE_LATENCY)))
    else $error("last flag out of step with its item");

  a_sign_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (gated_product != 0)) |->
      (gated_product[31] == $past(gate_value[15] ^ up_value[15], PIPE_LATENCY)))
    else $error("result sign does not match gate and up signs");
`endif

endmodule
`default_nettype wire

// ===== sim/swiglu_activation_checker.sv =====
// Result checker for the SwiGLU activation block: predicts and compares each result.
`timescale 1ns / 1ps
`default_nettype none
module swiglu_activation_checker (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire                        busy,
  input  wire signed [15:0]          gate_value,
  input  wire signed [15:0]          up_value,
  input  wire                        last_element,
  input  wire                        cfg_we,
  input  wire [swg_pkg::TERMS_W-1:0] cfg_data,
  input  wire                        result_valid,
  input  wire signed [31:0]          gated_product,
  input  wire                        last_out,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  typedef struct packed {
    logic [31:0] product;
    logic        last;
  } swiglu_result_t;

  swiglu_result_t expected_results[$];
  logic [swg_pkg::TERMS_W-1:0] terms_shadow;

  localparam logic [63:0] EXP_COEF [0:10] = '{
    64'd16777216, 64'd16777216, 64'd8388608, 64'd2796203, 64'd699051, 64'd139810,
    64'd23302, 64'd3329, 64'd416, 64'd46, 64'd5
  };

  function automatic logic [31:0] swiglu_product(input logic [15:0] g, input logic [15:0] u,
                                                 input logic [3:0] terms);
    logic [63:0] gmag, umag, a, acc, d, sn, s, mag, rmag;
    int n;
    gmag = g[15] ? 64'(17'h10000 - g) : 64'(g);
    umag = u[15] ? 64'(17'h10000 - u) : 64'(u);
    a = gmag << 12;
    n = (terms > 10) ? 10 : terms;
    acc = EXP_COEF[n];
    for (int i = n - 1; i >= 0; i--)
      acc = EXP_COEF[i] + ((acc * a + 64'd8388608) >> 24);
    d = 64'd16777216 + acc;
    sn = ((64'd1 << 48) + (d >> 1)) / d;
    s = g[15] ? sn : 64'd16777216 - sn;
    mag = gmag * s * umag;
    rmag = (mag + 64'd8388608) >> 24;
    return (g[15] != u[15]) ? 32'(64'd0 - rmag) : rmag[31:0];
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      terms_shadow <= 4'd10;
      fail_count <= 0;
      checked <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) terms_shadow <= cfg_data;
      // predict from the item taken at this edge, using the register value before it
      if (start && !busy)
        expected_results.push_back({swiglu_product(gate_value, up_value, terms_shadow),
                                    last_element});
      if (result_valid) begin
        swiglu_result_t want;
        int errs;
        errs = 0;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: gated_product %0d", gated_product);
          errs = 1;
        end else begin
          want = expected_results.pop_front();
          checked <= checked + 1;
          if (want.product !== gated_product) begin
            $error("gated_product expected %0d actual %0d", $signed(want.product),
                   gated_product);
            errs = errs + 1;
          end
          if (want.last !== last_out) begin
            $error("last_out expected %0b actual %0b", want.last, last_out);
            errs = errs + 1;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/swiglu_activation_test.sv =====
// Testbench top for the SwiGLU activation block: stimulus, register phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module swiglu_activation_test;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = swg_pkg::PIPE_LATENCY + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] gate_value = '0;
  logic signed [15:0] up_value = '0;
  logic last_element = 1'b0;
  logic cfg_we = 1'b0;
  logic [swg_pkg::TERMS_W-1:0] cfg_data = '0;
  logic busy, result_valid, last_out;
  logic signed [31:0] gated_product;
  int fail_count, pending, checked;
  int cycle_count = 0;
  int idle_pct = 0;

  always #10 clk = ~clk;

  swiglu_activation i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .gate_value(gate_value), .up_value(up_value), .last_element(last_element),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid), .gated_product(gated_product), .last_out(last_out)
  );

  swiglu_activation_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .gate_value(gate_value), .up_value(up_value), .last_element(last_element),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_valid(result_valid), .gated_product(gated_product), .last_out(last_out),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one item: hold start until it is taken; idle first at the current rate.
  task automatic send_item(input logic [15:0] g, input logic [15:0] u, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    gate_value <= g;
    up_value <= u;
    last_element <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain the pipeline fully, then write the register while nothing is in flight.
  task automatic set_terms(input logic [3:0] terms);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= terms;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random gates over the full range, with small values and edges mixed in.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(64)) - 32);
      3, 4: return 16'(int'($urandom_range(16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] term_plan [0:7];
    int idle_plan [0:3];
    int sent;
    term_plan = '{4'd10, 4'd0, 4'd1, 4'd15, 4'd5, 4'd11, 4'd3, 4'd10};
    idle_plan = '{0, 56, 0, 22};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero, signs, last flag, at the reset register value.
    send_item(16'h8000, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(16'h7FFF, 16'h8000, 1'b1);
    send_item(16'h7FFF, 16'h7FFF, 1'b0);
    send_item(16'h0000, 16'h7FFF, 1'b1);
    send_item(16'h0001, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'h0001, 1'b1);
    send_item(16'h1000, 16'h1000, 1'b0);
    send_item(16'hF000, 16'h1000, 1'b1);
    send_item(16'h5555, 16'hAAAA, 1'b0);
    send_item(16'hAAAA, 16'h5555, 1'b1);
    // Zero terms (sigmoid 0.5) and saturated term count at the extremes.
    set_terms(4'd0);
    send_item(16'h8000, 16'h7FFF, 1'b1);
    send_item(16'h7FFF, 16'h7FFF, 1'b0);
    send_item(16'h0000, 16'h8000, 1'b1);
    set_terms(4'd15);
    send_item(16'h8000, 16'h8000, 1'b0);
    send_item(16'h7FFF, 16'h1234, 1'b1);
    send_item(16'hC000, 16'h4000, 1'b0);

    // Random phases: one register setting and one idling rate each.
    for (int phase = 0; phase < 8; phase++) begin
      set_terms(term_plan[phase]);
      idle_pct = idle_plan[phase % 4];
      sent = 0;
      while (sent < 230) begin
        send_item(pick_value(), 16'($urandom), 1'($urandom));
        sent++;
      end
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d results over term counts 0, 1, 3, 5, 10, 11, 15", checked);
    $display("with sender idle rates of 0, 22 and 56 percent");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
